// ===== design/ordered_list_append_delete_top_defines.svh =====
// Assertion macros shared by the ordered list RTL
`ifndef ORDERED_LIST_APPEND_DELETE_TOP_DEFINES_SVH
`define ORDERED_LIST_APPEND_DELETE_TOP_DEFINES_SVH

// Check a property on an explicit clock and active-low reset
`define OLAD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on the standard clock and reset
`define OLAD_ASSERT(lbl, prop, msg) \
  `OLAD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== design/olad_pkg.sv =====
// Shared types and constants for the ordered list block
`default_nettype none

package olad_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int CNT_W   = 7;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ===== design/olad_if.sv =====
// Handshake interfaces for the command and result words
`default_nettype none

interface olad_in_if import olad_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [VALUE_W-1:0] value;
  logic        [POS_W-1:0]   position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink   (input valid, input operation, input value, input position,
                  output ready);
endinterface

interface olad_out_if import olad_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [1:0]         status;
  logic signed [VALUE_W-1:0] removed_value;
  logic        [CNT_W-1:0]   entry_count;

  modport source (output valid, output status, output removed_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input removed_value,
                  input entry_count, output ready);
endinterface

`default_nettype wire

// ===== design/olad_ram.sv =====
// Generic single-clock RAM, one write and one registered read port
`default_nettype none

module olad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/ordered_list_append_delete_top.sv =====
// Ordered list top level: append at tail, delete by position, one RAM holds entries
//
// The list lives in one RAM of CAPACITY 32-bit words with a registered read
// port; a register holds the entry count. An append, a full append and a bad
// position each go from idle straight to the done state, from which the result
// word is registered. A delete reads the removed entry, then moves every later
// entry down one place at one entry per cycle over the RAM's read and write
// ports. The command side is ready only while the sequencer is idle; a finished
// result sits in an output register, and the next command is taken while it
// waits. No clearing pass is needed after reset.
`default_nettype none
`include "ordered_list_append_delete_top_defines.svh"

module ordered_list_append_delete_top import olad_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  olad_in_if.sink        in_i,
  olad_out_if.source     out_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      idx_q, idx_d;
  status_e            res_status_q, res_status_d;
  logic [VALUE_W-1:0] res_removed_q, res_removed_d;

  logic               out_valid_q;
  status_e            out_status_q;
  logic [VALUE_W-1:0] out_removed_q;
  logic [CNT_W-1:0]   out_count_q;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic               accept;
  logic               out_free;
  logic [XW-1:0]      pos_x, cnt_x, idx_x;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign pos_x = XW'(in_i.position);
  assign cnt_x = XW'(count_q);
  assign idx_x = XW'(idx_q);

  olad_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    res_status_d  = res_status_q;
    res_removed_d = res_removed_q;
    ram_we        = 1'b0;
    ram_waddr     = idx_q;
    ram_wdata     = ram_rdata;
    ram_raddr     = idx_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_removed_d = '0;
          if (in_i.operation == OP_APPEND) begin
            state_d = S_DONE;
            if (cnt_x == XW'(CAPACITY)) begin
              res_status_d = ST_FULL;
            end else begin
              res_status_d = ST_DONE;
              ram_we       = 1'b1;
              ram_waddr    = count_q[AW-1:0];
              ram_wdata    = $unsigned(in_i.value);
              count_d      = count_q + 1'b1;
            end
          end else if ((pos_x == '0) || (pos_x > cnt_x)) begin
            res_status_d = ST_BADPOS;
            state_d      = S_DONE;
          end else begin
            ram_raddr = AW'(pos_x - 1'b1);
            idx_d     = AW'(pos_x - 1'b1);
            state_d   = S_READ;
          end
        end
      end
      S_READ: begin
        res_removed_d = ram_rdata;
        res_status_d  = ST_DONE;
        if ((idx_x + 1'b1) < cnt_x) begin
          ram_raddr = AW'(idx_x + 1'b1);
          state_d   = S_SHIFT;
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        idx_d     = idx_q + 1'b1;
        if ((idx_x + 2'd2) < cnt_x) begin
          ram_raddr = AW'(idx_x + 2'd2);
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    res_status_q  <= res_status_d;
    res_removed_q <= res_removed_d;
    if ((state_q == S_DONE) && out_free) begin
      out_status_q  <= res_status_q;
      out_removed_q <= res_removed_q;
      out_count_q   <= CNT_W'(count_q);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.removed_value = $signed(out_removed_q);
  assign out_o.entry_count   = out_count_q;

  `OLAD_ASSERT(a_count_bound, (XW'(count_q) <= XW'(CAPACITY)), "entry count above capacity")
  `OLAD_ASSERT(a_shift_in_list, (state_q == S_SHIFT) |-> ((idx_x + 1'b1) < cnt_x), "shift past tail")
  `OLAD_ASSERT(a_accept_leaves_idle, accept |=> (state_q != S_IDLE), "accepted word left idle")
  `OLAD_ASSERT(a_reject_no_removed, (out_valid_q && (out_status_q != ST_DONE)) |-> (out_removed_q == '0), "rejected word carries removed value")

endmodule

`default_nettype wire

// ===== tb/ordered_list_append_delete_top_tb.sv =====
// Testbench for the ordered list block: mirrored list model, directed and random traffic
`default_nettype none

module ordered_list_append_delete_top_tb;
  import olad_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int WORD_GOAL   = 700;
  localparam int SETTLE      = 120;
  localparam int CYCLE_LIMIT = 600000;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    status_e                   status;
    logic signed [VALUE_W-1:0] removed_value;
    logic        [CNT_W-1:0]   entry_count;
  } list_reply_t;

  class ordered_list_mirror;
    logic signed [VALUE_W-1:0] entries[$];
    list_reply_t               owed_replies[$];
    int                        errors;

    function void apply_command(logic op, logic signed [VALUE_W-1:0] val,
                                logic [POS_W-1:0] pos);
      list_reply_t reply;
      reply.status        = ST_DONE;
      reply.removed_value = '0;
      if (op == OP_APPEND) begin
        if (entries.size() >= CAPACITY) begin
          reply.status = ST_FULL;
        end else begin
          entries.push_back(val);
        end
      end else if (pos == 0 || int'(pos) > entries.size()) begin
        reply.status = ST_BADPOS;
      end else begin
        reply.removed_value = entries[pos - 1];
        entries.delete(pos - 1);
      end
      reply.entry_count = CNT_W'(entries.size());
      owed_replies.push_back(reply);
    endfunction

    function void flag(string field, string wanted, string seen);
      errors++;
      $display("%0t: %s mismatch, expected %s, got %s", $time, field, wanted, seen);
    endfunction

    function void check_reply(logic [1:0] st, logic signed [VALUE_W-1:0] rv,
                              logic [CNT_W-1:0] cnt);
      list_reply_t want;
      if (owed_replies.size() == 0) begin
        flag("unexpected word", "none", $sformatf("status %0d count %0d", st, cnt));
        return;
      end
      want = owed_replies.pop_front();
      if (st !== want.status)
        flag("status", $sformatf("%0d", want.status), $sformatf("%0d", st));
      if (rv !== want.removed_value)
        flag("removed_value", $sformatf("%0d", want.removed_value), $sformatf("%0d", rv));
      if (cnt !== want.entry_count)
        flag("entry_count", $sformatf("%0d", want.entry_count), $sformatf("%0d", cnt));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  olad_in_if  cmd_if ();
  olad_out_if rsp_if ();

  ordered_list_append_delete_top #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (rsp_if)
  );

  ordered_list_mirror mirror = new;
  int                 words_sent;
  int                 cycle_count;
  bit                 steady_flow;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int draw_wait();
    return steady_flow ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position(int cnt);
    int r;
    r = $urandom_range(0, 11);
    if (r == 0)
      return '0;
    if (r == 1 || cnt == 0)
      return POS_W'($urandom_range(cnt + 1, 127));
    if (r == 2)
      return POS_W'(cnt);
    if (r == 3)
      return POS_W'(1);
    return POS_W'($urandom_range(1, cnt));
  endfunction

  task automatic send_word(logic op, logic signed [VALUE_W-1:0] val, logic [POS_W-1:0] pos);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.operation <= op;
    cmd_if.value     <= val;
    cmd_if.position  <= pos;
    do @(posedge clk_i); while (!cmd_if.ready);
    mirror.apply_command(op, val, pos);
    words_sent++;
  endtask

  task automatic append(logic signed [VALUE_W-1:0] val);
    send_word(OP_APPEND, val, POS_W'($urandom));
  endtask

  task automatic remove(logic [POS_W-1:0] pos);
    send_word(OP_DELETE, $urandom, pos);
  endtask

  task automatic run_directed();
    remove(7'd1);
    remove(7'd0);
    remove(7'd127);
    send_word(OP_APPEND, VAL_MIN, 7'd127);
    send_word(OP_APPEND, VAL_MAX, 7'd0);
    append('0);
    append(-1);
    remove(7'd0);
    remove(7'd5);
    send_word(OP_DELETE, VAL_MAX, 7'd2);
    send_word(OP_DELETE, VAL_MIN, 7'd3);
    remove(7'd1);
    remove(7'd2);
    remove(7'd1);
    remove(7'd1);
    append(32'sh5555_5555);
    append(32'shAAAA_AAAA);
    remove(7'd1);
    remove(7'd64);
    remove(7'd1);
  endtask

  task automatic run_random();
    int n;
    while (words_sent < WORD_GOAL) begin
      steady_flow = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: begin
          while (mirror.entries.size() < CAPACITY) begin
            if ($urandom_range(0, 9) == 0)
              remove(pick_position(mirror.entries.size()));
            else
              append(pick_value());
          end
          repeat ($urandom_range(1, 3)) append(pick_value());
          if ($urandom_range(0, 1) == 0)
            remove(7'd64);
        end
        1: begin
          while (mirror.entries.size() > 0)
            remove(pick_position(mirror.entries.size()));
          repeat ($urandom_range(1, 2)) remove(pick_position(0));
        end
        2: begin
          n = $urandom_range(10, 40);
          repeat (n) begin
            if ($urandom_range(0, 1) == 0)
              append(pick_value());
            else
              remove(pick_position(mirror.entries.size()));
          end
        end
        default: begin
          n = $urandom_range(5, 15);
          repeat (n) begin
            send_word(1'($urandom_range(0, 1)), $urandom,
                      POS_W'($urandom_range(0, 127)));
          end
        end
      endcase
    end
  endtask

  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      mirror.check_reply(rsp_if.status, rsp_if.removed_value, rsp_if.entry_count);
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    cmd_if.valid     <= 1'b0;
    cmd_if.operation <= OP_APPEND;
    cmd_if.value     <= '0;
    cmd_if.position  <= '0;
    cycle_count      = 0;
    words_sent       = 0;
    steady_flow      = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    cmd_if.valid <= 1'b0;
    while (mirror.owed_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== ordered_list_append_delete_top.f =====
+incdir+design
design/olad_pkg.sv
design/olad_if.sv
design/olad_ram.sv
design/ordered_list_append_delete_top.sv
tb/ordered_list_append_delete_top_tb.sv
